>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the filter checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/blf_pkg.sv
// ---------------------------------------------------------------------------
// blf_pkg
// widths, control word layout and microprogram of the biquad filter
// ---------------------------------------------------------------------------
`default_nettype none

package blf_pkg;

  // number formats
  localparam int SAMPLE_BITS    = 16;
  localparam int STATE_BITS     = 40;
  localparam int COEF_FRAC_BITS = 16;
  localparam int STATE_FRAC     = 8;
  localparam int COEF_BITS      = 4 + COEF_FRAC_BITS;
  localparam int PROD_FRAC      = STATE_FRAC + COEF_FRAC_BITS;

  // state words are multiplied in two halves
  localparam int LO_BITS    = STATE_BITS / 2;
  localparam int HI_BITS    = STATE_BITS - LO_BITS;
  localparam int CHUNK_BITS = HI_BITS + 1;
  localparam int PROD_BITS  = CHUNK_BITS + COEF_BITS;
  localparam int ACC_BITS   = STATE_BITS + COEF_BITS + 2;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = COEF_BITS;

  // microprogram size
  localparam int NUM_STEPS = 15;
  localparam int PC_BITS   = $clog2(NUM_STEPS);

  localparam logic [PC_BITS-1:0] STEP_IDLE = PC_BITS'(0);
  localparam logic [PC_BITS-1:0] STEP_PASS = PC_BITS'(14);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FILTER_ENABLE = 3'd0,
    REG_COEF_B0       = 3'd1,
    REG_COEF_B1       = 3'd2,
    REG_COEF_B2       = 3'd3,
    REG_COEF_A1       = 3'd4,
    REG_COEF_A2       = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_BYPASS
  } cond_e;

  typedef enum logic [1:0] {
    OPND_D1,
    OPND_D2,
    OPND_W
  } opnd_e;

  typedef enum logic [2:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2
  } coef_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_LOADX,
    ACC_ADD,
    ACC_SUB
  } acc_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_FILT,
    OUT_PASS
  } out_e;

  // one control word of the microprogram
  typedef struct packed {
    logic               accept;
    wait_e              wait_on;
    cond_e              cond;
    logic [PC_BITS-1:0] target;
    opnd_e              opnd;
    logic               half_hi;
    coef_e              coef;
    acc_e               acc_op;
    logic               w_fix;
    out_e               out_op;
  } ctl_t;

  // status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic enable;
  } stat_t;

  // coefficient set
  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coefs_t;

  function automatic ctl_t uword(logic acpt, wait_e wt, cond_e cd, logic [PC_BITS-1:0] tg,
                                 opnd_e op, logic hi, coef_e cf, acc_e ac, logic wf,
                                 out_e oo);
    ctl_t c;
    c.accept  = acpt;
    c.wait_on = wt;
    c.cond    = cd;
    c.target  = tg;
    c.opnd    = op;
    c.half_hi = hi;
    c.coef    = cf;
    c.acc_op  = ac;
    c.w_fix   = wf;
    c.out_op  = oo;
    return c;
  endfunction

  // microprogram: the product issued in a step is accumulated in the next
  function automatic ctl_t ucode(logic [PC_BITS-1:0] pc);
    ctl_t c;
    case (pc)
      // wait for a sample transfer
      0:  c = uword(1'b1, WAIT_IN, COND_NEVER, STEP_IDLE, OPND_D1, 1'b0, COEF_A1,
                    ACC_HOLD, 1'b0, OUT_NONE);
      // load x, branch off when disabled
      1:  c = uword(1'b0, WAIT_NONE, COND_BYPASS, STEP_PASS, OPND_D1, 1'b0, COEF_A1,
                    ACC_LOADX, 1'b0, OUT_NONE);
      // feedback terms
      2:  c = uword(1'b0, WAIT_NONE, COND_NEVER, STEP_IDLE, OPND_D1, 1'b1, COEF_A1,
                    ACC_SUB, 1'b0, OUT_NONE);
      3:  c = uword(1'b0, WAIT_NONE, COND_NEVER, STEP_IDLE, OPND_D2, 1'b0, COEF_A2,
                    ACC_SUB, 1'b0, OUT_NONE);
      4:  c = uword(1'b0, WAIT_NONE, COND_NEVER, STEP_IDLE, OPND_D2, 1'b1, COEF_A2,
                    ACC_SUB, 1'b0, OUT_NONE);
      5:  c = uword(1'b0, WAIT_NONE, COND_NEVER, STEP_IDLE, OPND_D1, 1'b0, COEF_B1,
                    ACC_SUB, 1'b0, OUT_NONE);
      // round w, start the feedforward sum
      6:  c = uword(1'b0, WAIT_NONE, COND_NEVER, STEP_IDLE, OPND_D1, 1'b0, COEF_B1,
                    ACC_CLR, 1'b1, OUT_NONE);
      7:  c = uword(1'b0, WAIT_NONE, COND_NEVER, STEP_IDLE, OPND_D1, 1'b1, COEF_B1,
                    ACC_ADD, 1'b0, OUT_NONE);
      8:  c = uword(1'b0, WAIT_NONE, COND_NEVER, STEP_IDLE, OPND_D2, 1'b0, COEF_B2,
                    ACC_ADD, 1'b0, OUT_NONE);
      9:  c = uword(1'b0, WAIT_NONE, COND_NEVER, STEP_IDLE, OPND_D2, 1'b1, COEF_B2,
                    ACC_ADD, 1'b0, OUT_NONE);
      10: c = uword(1'b0, WAIT_NONE, COND_NEVER, STEP_IDLE, OPND_W, 1'b0, COEF_B0,
                    ACC_ADD, 1'b0, OUT_NONE);
      11: c = uword(1'b0, WAIT_NONE, COND_NEVER, STEP_IDLE, OPND_W, 1'b1, COEF_B0,
                    ACC_ADD, 1'b0, OUT_NONE);
      12: c = uword(1'b0, WAIT_NONE, COND_NEVER, STEP_IDLE, OPND_W, 1'b1, COEF_B0,
                    ACC_ADD, 1'b0, OUT_NONE);
      // write filtered result and shift the delay line
      13: c = uword(1'b0, WAIT_OUT, COND_ALWAYS, STEP_IDLE, OPND_D1, 1'b0, COEF_B0,
                    ACC_HOLD, 1'b0, OUT_FILT);
      // write pass-through result
      14: c = uword(1'b0, WAIT_OUT, COND_ALWAYS, STEP_IDLE, OPND_D1, 1'b0, COEF_B0,
                    ACC_HOLD, 1'b0, OUT_PASS);
      default: c = uword(1'b0, WAIT_NONE, COND_ALWAYS, STEP_IDLE, OPND_D1, 1'b0, COEF_B0,
                         ACC_HOLD, 1'b0, OUT_NONE);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/blf_sequencer.sv
// ---------------------------------------------------------------------------
// blf_sequencer
// step counter over the microprogram table with waits and jumps
// ---------------------------------------------------------------------------
`default_nettype none

module blf_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  blf_pkg::stat_t stat_i,
  output blf_pkg::ctl_t  ctl_o
);
  import blf_pkg::*;

  logic [PC_BITS-1:0] pc_q, pc_d;
  ctl_t               word;
  logic               stall;
  logic               jump;

  // fetch the control word of the current step
  always_comb word = ucode(pc_q);

  // wait, jump and action gating
  always_comb begin
    case (word.wait_on)
      WAIT_IN:  stall = !stat_i.in_valid;
      WAIT_OUT: stall = !stat_i.out_free;
      default:  stall = 1'b0;
    endcase

    case (word.cond)
      COND_ALWAYS: jump = 1'b1;
      COND_BYPASS: jump = !stat_i.enable;
      default:     jump = 1'b0;
    endcase

    if (stall) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end

    ctl_o = word;
    if (stall) begin
      ctl_o.acc_op = ACC_HOLD;
      ctl_o.w_fix  = 1'b0;
      ctl_o.out_op = OUT_NONE;
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/blf_datapath.sv
// ---------------------------------------------------------------------------
// blf_datapath
// shared half-word multiplier, accumulator, delay line and result register
// ---------------------------------------------------------------------------
`default_nettype none

module blf_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  blf_pkg::ctl_t                         ctl_i,
  input  blf_pkg::coefs_t                       coefs_i,
  input  logic                                  in_xfer_i,
  input  logic signed [blf_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                  out_ready_i,
  output logic                                  out_free_o,
  output logic                                  out_valid_o,
  output logic signed [blf_pkg::SAMPLE_BITS-1:0] filtered_o,
  output logic                                  overflow_o,
  output logic                                  clipped_o
);
  import blf_pkg::*;

  localparam int WTOP_LSB = COEF_FRAC_BITS + STATE_BITS - 1;
  localparam int YTOP_LSB = PROD_FRAC + SAMPLE_BITS - 1;

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [STATE_BITS-1:0]  d1_q, d2_q, w_q;
  logic                          ovf_q;
  logic signed [ACC_BITS-1:0]    p_q, acc_q, acc_d;

  logic signed [STATE_BITS-1:0]  opnd;
  logic signed [CHUNK_BITS-1:0]  chunk;
  logic signed [COEF_BITS-1:0]   coef;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    prod_ext, prod_sh;

  logic signed [ACC_BITS-1:0]    w_sum, y_sum;
  logic [ACC_BITS-WTOP_LSB-1:0]  w_top;
  logic [ACC_BITS-YTOP_LSB-1:0]  y_top;
  logic                          w_fits, y_fits;
  logic signed [STATE_BITS-1:0]  w_new, x_state;
  logic signed [SAMPLE_BITS-1:0] y_val;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] filt_q;
  logic                          ovf_out_q, clip_q;

  // operand selection and one signed half-word product
  always_comb begin
    case (ctl_i.opnd)
      OPND_D2: opnd = d2_q;
      OPND_W:  opnd = w_q;
      default: opnd = d1_q;
    endcase
    case (ctl_i.coef)
      COEF_B1: coef = coefs_i.b1;
      COEF_B2: coef = coefs_i.b2;
      COEF_A1: coef = coefs_i.a1;
      COEF_A2: coef = coefs_i.a2;
      default: coef = coefs_i.b0;
    endcase
    if (ctl_i.half_hi) begin
      chunk = {opnd[STATE_BITS-1], opnd[STATE_BITS-1:LO_BITS]};
    end else begin
      chunk = {{(CHUNK_BITS-LO_BITS){1'b0}}, opnd[LO_BITS-1:0]};
    end
    prod     = chunk * coef;
    prod_ext = {{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
    prod_sh  = ctl_i.half_hi ? (prod_ext <<< LO_BITS) : prod_ext;
  end

  // accumulator update
  always_comb begin
    case (ctl_i.acc_op)
      ACC_CLR:   acc_d = '0;
      ACC_LOADX: acc_d = {{(ACC_BITS-SAMPLE_BITS-PROD_FRAC){x_q[SAMPLE_BITS-1]}}, x_q,
                          {PROD_FRAC{1'b0}}};
      ACC_ADD:   acc_d = acc_q + p_q;
      ACC_SUB:   acc_d = acc_q - p_q;
      default:   acc_d = acc_q;
    endcase
  end

  // round w to the state format, substitute the sample on overflow
  always_comb begin
    x_state = {{(STATE_BITS-SAMPLE_BITS-STATE_FRAC){x_q[SAMPLE_BITS-1]}}, x_q,
               {STATE_FRAC{1'b0}}};
    w_sum   = acc_q + (ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1));
    w_top   = w_sum[ACC_BITS-1:WTOP_LSB];
    w_fits  = (&w_top) || !(|w_top);
    w_new   = w_fits ? w_sum[WTOP_LSB:COEF_FRAC_BITS] : x_state;
  end

  // round y to an integer and saturate
  always_comb begin
    y_sum  = acc_q + (ACC_BITS'(1) <<< (PROD_FRAC - 1));
    y_top  = y_sum[ACC_BITS-1:YTOP_LSB];
    y_fits = (&y_top) || !(|y_top);
    if (y_fits) begin
      y_val = y_sum[YTOP_LSB:PROD_FRAC];
    end else if (y_sum[ACC_BITS-1]) begin
      y_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign out_free_o = !out_valid_q || out_ready_i;

  // sample, product, accumulator and w registers
  always_ff @(posedge clk_i) begin
    if (in_xfer_i) begin
      x_q <= sample_i;
    end
    p_q   <= prod_sh;
    acc_q <= acc_d;
    if (ctl_i.w_fix) begin
      w_q   <= w_new;
      ovf_q <= !w_fits;
    end
  end

  // delay line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (ctl_i.out_op == OUT_FILT) begin
      d2_q <= d1_q;
      d1_q <= w_q;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_op != OUT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    case (ctl_i.out_op)
      OUT_FILT: begin
        filt_q    <= y_val;
        ovf_out_q <= ovf_q;
        clip_q    <= !y_fits;
      end
      OUT_PASS: begin
        filt_q    <= x_q;
        ovf_out_q <= 1'b0;
        clip_q    <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filt_q;
  assign overflow_o  = ovf_out_q;
  assign clipped_o   = clip_q;

endmodule

`default_nettype wire

>>> rtl/core/biquad_lowpass_filter.sv
// ---------------------------------------------------------------------------
// biquad_lowpass_filter
// the filtered result is written after the feedback and feedforward sums, the
//   pass-through result (filter disabled) without them
// one sample at a time: the next sample is taken once the result is written; the
//   single 20x21 multiplier does five products in two halves each
// reset: async, clears step counter, delay line and configuration; no result valid
// ---------------------------------------------------------------------------
`default_nettype none

module biquad_lowpass_filter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [blf_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [blf_pkg::CFG_DATA_BITS-1:0]      cfg_wdata_i,
  // sample channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [blf_pkg::SAMPLE_BITS-1:0] sample_in_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [blf_pkg::SAMPLE_BITS-1:0] filtered_out_o,
  output logic                                   state_overflow_o,
  output logic                                   output_clipped_o
);
  import blf_pkg::*;

  logic   enable_q;
  coefs_t coefs_q;
  ctl_t   ctl;
  stat_t  stat;
  logic   out_free;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      coefs_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FILTER_ENABLE: enable_q   <= cfg_wdata_i[0];
        REG_COEF_B0:       coefs_q.b0 <= cfg_wdata_i;
        REG_COEF_B1:       coefs_q.b1 <= cfg_wdata_i;
        REG_COEF_B2:       coefs_q.b2 <= cfg_wdata_i;
        REG_COEF_A1:       coefs_q.a1 <= cfg_wdata_i;
        REG_COEF_A2:       coefs_q.a2 <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // status for the sequencer
  always_comb begin
    stat.in_valid = in_valid_i;
    stat.out_free = out_free;
    stat.enable   = enable_q;
  end

  assign in_ready_o = ctl.accept;

  blf_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  blf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .coefs_i     (coefs_q),
    .in_xfer_i   (in_valid_i && ctl.accept),
    .sample_i    (sample_in_i),
    .out_ready_i (out_ready_i),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .filtered_o  (filtered_out_o),
    .overflow_o  (state_overflow_o),
    .clipped_o   (output_clipped_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/blf_checker.sv
// ---------------------------------------------------------------------------
// blf_checker
// port-level checks of the biquad filter, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module blf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] filtered_out_o,
  input logic        state_overflow_o,
  input logic        output_clipped_o
);

  logic        in_xfer;
  logic        out_stalled;
  logic [17:0] out_payload;

  // handshake and payload shorthands
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_stalled = out_valid_o && !out_ready_i;
  assign out_payload = {filtered_out_o, state_overflow_o, output_clipped_o};

  // one sample at a time: ready drops right after a transfer
  `ASSERT_NEXT(a_ready_drops, clk_i, rst_ni, in_xfer, !in_ready_o)

  // no result appears in the cycle right after a sample transfer
  `ASSERT_IMPLY(a_no_instant_result, clk_i, rst_ni, $rose(out_valid_o), !$past(in_xfer))

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stalled, out_valid_o && $stable(out_payload))

endmodule

bind biquad_lowpass_filter blf_checker u_blf_checker (.*);

`default_nettype wire
